// ===== design/sstf_pkg.sv =====
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and helpers for the shortest-seek-first disk scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

	localparam int CYL_W   = 16;
	localparam int TOTAL_W = 22;

	typedef logic [CYL_W-1:0]   cyl_t;
	typedef logic [TOTAL_W-1:0] total_t;

	// best request seen so far as it walks down the chain
	typedef struct packed {
		logic found;
		cyl_t cyl;
		cyl_t seek;
	} cand_t;

	// controls broadcast from the controller to every cell
	typedef struct packed {
		logic load;
		logic mark;
		logic clear;
	} cell_ctl_t;

	typedef enum logic {
		ST_LOAD,
		ST_SEARCH
	} state_t;

	function automatic cyl_t abs_diff(input cyl_t a, input cyl_t b);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

// ===== design/sstf_cell.sv =====
// ----------------------------------------------------------------------------
// sstf_cell
// One request slot: holds a cylinder with its valid and served marks and
// folds itself into the nearest-request candidate passing through.
// ----------------------------------------------------------------------------
module sstf_cell
	import sstf_pkg::*;
#(
	parameter int IDX_W = 5,
	parameter int IDX   = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [IDX_W-1:0] wr_idx,
	input  cyl_t             wr_cyl,
	input  logic [IDX_W-1:0] mark_idx,
	input  cyl_t             head,
	input  cand_t            cand_in,
	input  logic [IDX_W-1:0] idx_in,
	output cand_t            cand_out,
	output logic [IDX_W-1:0] idx_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	cyl_t             cyl_q;
	logic             valid_q;
	logic             served_q;
	cand_t            cand_q;
	logic [IDX_W-1:0] idx_q;

	cyl_t seek;
	logic live;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			served_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q  <= 1'b0;
			served_q <= 1'b0;
		end else begin
			if (ctl.load && wr_idx == MY_IDX) begin
				valid_q <= 1'b1;
			end
			if (ctl.mark && mark_idx == MY_IDX) begin
				served_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && wr_idx == MY_IDX) begin
			cyl_q <= wr_cyl;
		end
	end

	always_comb begin
		seek = abs_diff(cyl_q, head);
		live = valid_q && !served_q;
		// nearer wins, equal distance goes to the lower cylinder
		take = live && (!cand_in.found || seek < cand_in.seek ||
			(seek == cand_in.seek && cyl_q < cand_in.cyl));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			idx_q  <= '0;
		end else if (take) begin
			cand_q <= '{found: 1'b1, cyl: cyl_q, seek: seek};
			idx_q  <= MY_IDX;
		end else begin
			cand_q <= cand_in;
			idx_q  <= idx_in;
		end
	end

	assign cand_out = cand_q;
	assign idx_out  = idx_q;

endmodule

// ===== design/sstf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sstf_ctrl
// Batch controller: loads requests, times each walk of the cell chain,
// moves the head and registers one result word per pick.
// ----------------------------------------------------------------------------
module sstf_ctrl
	import sstf_pkg::*;
#(
	parameter int N     = 32,
	parameter int CNT_W = 6,
	parameter int IDX_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cyl_t             cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  cyl_t             in_cyl,
	input  logic             in_last,
	output logic             out_valid,
	input  logic             out_ready,
	output cyl_t             out_cyl,
	output cyl_t             out_dist,
	output total_t           out_total,
	output logic             out_last,
	output logic             out_drop,
	output cell_ctl_t        ctl,
	output logic [IDX_W-1:0] wr_idx,
	output cyl_t             wr_cyl,
	output logic [IDX_W-1:0] mark_idx,
	output cyl_t             head,
	input  cand_t            tail_cand,
	input  logic [IDX_W-1:0] tail_idx
);

	localparam logic [CNT_W-1:0] FULL = CNT_W'(N);

	state_t           state_q, state_d;
	cyl_t             start_q;
	cyl_t             head_q;
	total_t           total_q;
	total_t           total_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pick_q;
	logic [CNT_W-1:0] scnt_q;
	logic             ovf_q;
	logic             out_valid_q;
	cyl_t             out_cyl_q;
	cyl_t             out_dist_q;
	total_t           out_total_q;
	logic             out_last_q;
	logic             out_drop_q;

	logic in_fire;
	logic launch;
	logic pick;
	logic last_pick;
	logic slot_free;

	always_comb begin
		in_fire   = in_valid && in_ready;
		launch    = in_fire && in_last;
		slot_free = !out_valid_q || out_ready;
		pick      = (state_q == ST_SEARCH) && (scnt_q == FULL) && slot_free;
		last_pick = pick && (CNT_W'(pick_q + 1'b1) == count_q);
		total_d   = total_q + TOTAL_W'(tail_cand.seek);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (launch) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (last_pick) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		ctl.load  = 1'b0;
		ctl.mark  = 1'b0;
		ctl.clear = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				ctl.load = in_valid && (count_q < FULL);
			end
			ST_SEARCH: begin
				ctl.mark  = pick;
				ctl.clear = last_pick;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			start_q <= '0;
			head_q  <= '0;
			total_q <= '0;
			count_q <= '0;
			pick_q  <= '0;
			scnt_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end
			if (last_pick) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (in_fire) begin
				if (count_q < FULL) begin
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (launch) begin
				head_q  <= start_q;
				total_q <= '0;
				pick_q  <= '0;
				scnt_q  <= '0;
			end else if (pick) begin
				head_q  <= tail_cand.cyl;
				total_q <= total_d;
				pick_q  <= pick_q + 1'b1;
				scnt_q  <= '0;
			end else if (state_q == ST_SEARCH && scnt_q != FULL) begin
				// advance while the candidate walks the chain
				scnt_q <= scnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pick) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pick) begin
			out_cyl_q   <= tail_cand.cyl;
			out_dist_q  <= tail_cand.seek;
			out_total_q <= total_d;
			out_last_q  <= last_pick;
			out_drop_q  <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_cyl   = out_cyl_q;
	assign out_dist  = out_dist_q;
	assign out_total = out_total_q;
	assign out_last  = out_last_q;
	assign out_drop  = out_drop_q;
	assign wr_idx    = count_q[IDX_W-1:0];
	assign wr_cyl    = in_cyl;
	assign mark_idx  = tail_idx;
	assign head      = head_q;

endmodule

// ===== design/sstf_disk_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// sstf_disk_scheduler_top
// Shortest-seek-first disk scheduler built as a chain of request cells.
// ----------------------------------------------------------------------------
//
//  port group   dir  word contents (lowest bit first)
//  s_axis_*     in   tdata: cylinder[15:0]; tlast: batch_end
//  m_axis_*     out  tdata: served_cylinder, seek_distance, total_seek, pad;
//                    tlast: final_pick; tuser: dropped
//  cfg_*        in   cfg_wdata: start_cylinder, written when cfg_we is high
//
//  Loading accepts one input word per cycle; the last word starts scheduling.
//  For each result the nearest-request candidate walks the whole cell chain,
//  one cell a cycle, before the head can move.
//  A stalled result holds the next pick; no clearing pass follows reset.
//  Input is refused from the batch's last word until its final pick.
// ----------------------------------------------------------------------------
module sstf_disk_scheduler_top
	import sstf_pkg::*;
#(
	parameter int MAX_REQUESTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,      // start_cylinder
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // cylinder[15:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// served_cylinder[15:0], seek_distance[31:16], total_seek[53:32], zero[55:54]
	output logic [55:0] m_axis_tdata,
	output logic        m_axis_tlast,
	output logic        m_axis_tuser    // dropped
);

	localparam int N     = MAX_REQUESTS;
	localparam int CNT_W = $clog2(N + 1);
	localparam int IDX_W = $clog2(N);

	cell_ctl_t        ctl;
	logic [IDX_W-1:0] wr_idx;
	cyl_t             wr_cyl;
	logic [IDX_W-1:0] mark_idx;
	cyl_t             head;
	cand_t            cand_w [0:N];
	logic [IDX_W-1:0] idx_w  [0:N];
	cyl_t             out_cyl;
	cyl_t             out_dist;
	total_t           out_total;

	sstf_ctrl #(
		.N     (N),
		.CNT_W (CNT_W),
		.IDX_W (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cyl    (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_cyl   (out_cyl),
		.out_dist  (out_dist),
		.out_total (out_total),
		.out_last  (m_axis_tlast),
		.out_drop  (m_axis_tuser),
		.ctl       (ctl),
		.wr_idx    (wr_idx),
		.wr_cyl    (wr_cyl),
		.mark_idx  (mark_idx),
		.head      (head),
		.tail_cand (cand_w[N]),
		.tail_idx  (idx_w[N])
	);

	// chain head sees no candidate yet
	assign cand_w[0] = '0;
	assign idx_w[0]  = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		sstf_cell #(
			.IDX_W (IDX_W),
			.IDX   (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_idx   (wr_idx),
			.wr_cyl   (wr_cyl),
			.mark_idx (mark_idx),
			.head     (head),
			.cand_in  (cand_w[i]),
			.idx_in   (idx_w[i]),
			.cand_out (cand_w[i+1]),
			.idx_out  (idx_w[i+1])
		);
	end

	assign m_axis_tdata = {2'b00, out_total, out_dist, out_cyl};

endmodule

// ===== design/sstf_checker.sv =====
// ----------------------------------------------------------------------------
// sstf_checker
// Port-level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module sstf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [15:0] cfg_wdata,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// a stalled result word must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	// batch end closes the input until the final pick
	a_lock_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input open right after batch end");

	// a non-final result means the batch is still being scheduled
	a_no_load_mid_batch: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input open during scheduling");

	// the running total includes the current seek
	a_total_ge_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[53:32] >= {6'd0, m_axis_tdata[31:16]})
		else $error("total seek below seek distance");

	// no new result directly follows a loading cycle
	a_no_result_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result raised while loading");

endmodule

bind sstf_disk_scheduler_top sstf_checker u_sstf_checker (.*);
